// ----- hdl/rvsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvsc_pkg
// shared opcodes, decoded-op types and constants of the rv32i subset core
// ----------------------------------------------------------------------------
package rvsc_pkg;

  localparam int unsigned DmemWordsDefault = 32;
  localparam int unsigned QueueDepth       = 2;

  localparam logic [6:0] OpRtype  = 7'b0110011;
  localparam logic [6:0] OpItype  = 7'b0010011;
  localparam logic [6:0] OpLoad   = 7'b0000011;
  localparam logic [6:0] OpStore  = 7'b0100011;
  localparam logic [6:0] OpBranch = 7'b1100011;
  localparam logic [6:0] OpJal    = 7'b1101111;
  localparam logic [6:0] OpJalr   = 7'b1100111;
  localparam logic [6:0] F7Alt    = 7'b0100000;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_ADDI, OP_ANDI, OP_ORI,
    OP_LW, OP_SW, OP_BEQ, OP_JAL, OP_JALR, OP_BAD
  } op_e;

  // decoded instruction handed from front to back
  typedef struct packed {
    op_e         op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } dec_t;

endpackage

// ----- hdl/rvsc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvsc_front
// decodes instruction words into ops and immediates, feeds a short queue
// ----------------------------------------------------------------------------
module rvsc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        instruction_i,
  output logic               dec_valid_o,
  input  logic               dec_take_i,
  output rvsc_pkg::dec_t     dec_o
);

  localparam int unsigned QD = rvsc_pkg::QueueDepth;

  rvsc_pkg::dec_t dec_d;
  rvsc_pkg::dec_t q_q [QD];
  logic           rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [31:0] w, imm_i, imm_s, imm_b, imm_j;

  always_comb begin
    w     = instruction_i;
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    dec_d.rd  = w[11:7];
    dec_d.rs1 = w[19:15];
    dec_d.rs2 = w[24:20];
    dec_d.imm = imm_i;
    dec_d.op  = rvsc_pkg::OP_BAD;
    unique case (opc)
      rvsc_pkg::OpRtype: begin
        if (f3 == 3'd0 && f7 == 7'd0) dec_d.op = rvsc_pkg::OP_ADD;
        else if (f3 == 3'd0 && f7 == rvsc_pkg::F7Alt) dec_d.op = rvsc_pkg::OP_SUB;
        else if (f3 == 3'd7 && f7 == 7'd0) dec_d.op = rvsc_pkg::OP_AND;
        else if (f3 == 3'd6 && f7 == 7'd0) dec_d.op = rvsc_pkg::OP_OR;
      end
      rvsc_pkg::OpItype: begin
        if (f3 == 3'd0) dec_d.op = rvsc_pkg::OP_ADDI;
        else if (f3 == 3'd7) dec_d.op = rvsc_pkg::OP_ANDI;
        else if (f3 == 3'd6) dec_d.op = rvsc_pkg::OP_ORI;
      end
      rvsc_pkg::OpLoad:  if (f3 == 3'd2) dec_d.op = rvsc_pkg::OP_LW;
      rvsc_pkg::OpStore: begin
        dec_d.imm = imm_s;
        if (f3 == 3'd2) dec_d.op = rvsc_pkg::OP_SW;
      end
      rvsc_pkg::OpBranch: begin
        dec_d.imm = imm_b;
        if (f3 == 3'd0) dec_d.op = rvsc_pkg::OP_BEQ;
      end
      rvsc_pkg::OpJal: begin
        dec_d.imm = imm_j;
        dec_d.op  = rvsc_pkg::OP_JAL;
      end
      rvsc_pkg::OpJalr: if (f3 == 3'd0) dec_d.op = rvsc_pkg::OP_JALR;
      default: dec_d.op = rvsc_pkg::OP_BAD;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'(QD));
  assign push        = in_valid_i && !in_stall_o;
  assign dec_valid_o = (cnt_q != 2'd0);
  assign pop         = dec_valid_o && dec_take_i;
  assign dec_o       = q_q[rd_ptr_q];

  always_comb begin
    rd_ptr_d = rd_ptr_q ^ pop;
    wr_ptr_d = wr_ptr_q ^ push;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_ptr_q] <= dec_d;
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QD)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(QD)) |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
`endif

endmodule

// ----- hdl/rvsc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvsc_back
// executes decoded ops against pc, register file and data memory
// ----------------------------------------------------------------------------
module rvsc_back #(
  parameter int unsigned DMEM_WORDS = rvsc_pkg::DmemWordsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               dec_valid_i,
  output logic               dec_take_o,
  input  rvsc_pkg::dec_t     dec_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        next_pc_o,
  output logic               reg_written_o,
  output logic [4:0]         dest_reg_o,
  output logic signed [31:0] dest_value_o,
  output logic               mem_stored_o,
  output logic [31:0]        store_address_o,
  output logic signed [31:0] store_value_o,
  output logic               unsupported_o
);

  localparam int unsigned AW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
  // reciprocal of the depth, exact for any 30-bit word index
  localparam logic [63:0] RecipM =
    ((64'd1 << (30 + AW)) + 64'(DMEM_WORDS) - 64'd1) / 64'(DMEM_WORDS);

  logic [31:0] pc_q, pc_d;
  logic [31:0] rf_q [32];
  logic        rf_vld_q [32];
  logic [31:0] mem_q [DMEM_WORDS];
  logic        mem_vld_q [DMEM_WORDS];
  logic        out_valid_q;

  logic [31:0] a, b, sum, val, npc, addr;
  logic [AW-1:0] widx;
  logic        wr, st, bad, fire;

  // word index modulo depth; bit slice for power-of-two depth, else reciprocal multiply
  function automatic logic [AW-1:0] idx_of(input logic [31:0] ad);
    logic [29:0] wi;
    logic [63:0] prod;
    logic [29:0] quo;
    logic [29:0] rem;
    wi   = ad[31:2];
    prod = 64'(wi) * RecipM;
    quo  = 30'(prod >> (30 + AW));
    rem  = wi - 30'(quo * 30'(DMEM_WORDS));
    if ((DMEM_WORDS & (DMEM_WORDS - 1)) == 0) return AW'(wi);
    else return AW'(rem);
  endfunction

  assign a    = rf_vld_q[dec_i.rs1] ? rf_q[dec_i.rs1] : 32'd0;
  assign b    = rf_vld_q[dec_i.rs2] ? rf_q[dec_i.rs2] : 32'd0;
  assign sum  = a + dec_i.imm;
  assign addr = sum;
  assign widx = idx_of(addr);

  always_comb begin
    wr  = 1'b0;
    st  = 1'b0;
    bad = 1'b0;
    val = 32'd0;
    npc = pc_q + 32'd4;
    unique case (dec_i.op)
      rvsc_pkg::OP_ADD:  begin wr = 1'b1; val = a + b; end
      rvsc_pkg::OP_SUB:  begin wr = 1'b1; val = a - b; end
      rvsc_pkg::OP_AND:  begin wr = 1'b1; val = a & b; end
      rvsc_pkg::OP_OR:   begin wr = 1'b1; val = a | b; end
      rvsc_pkg::OP_ADDI: begin wr = 1'b1; val = sum; end
      rvsc_pkg::OP_ANDI: begin wr = 1'b1; val = a & dec_i.imm; end
      rvsc_pkg::OP_ORI:  begin wr = 1'b1; val = a | dec_i.imm; end
      rvsc_pkg::OP_LW: begin
        wr  = 1'b1;
        val = mem_vld_q[widx] ? mem_q[widx] : 32'd0;
      end
      rvsc_pkg::OP_SW:   st = 1'b1;
      rvsc_pkg::OP_BEQ:  if (a == b) npc = pc_q + dec_i.imm;
      rvsc_pkg::OP_JAL:  begin wr = 1'b1; val = pc_q + 32'd4; npc = pc_q + dec_i.imm; end
      rvsc_pkg::OP_JALR: begin wr = 1'b1; val = pc_q + 32'd4; npc = sum; end
      default:           bad = 1'b1;
    endcase
    if (dec_i.rd == 5'd0) wr = 1'b0;
    if (!wr) val = 32'd0;
    pc_d = npc;
  end

  // output register frees whenever it is empty or being taken
  assign dec_take_o  = !out_valid_q || !out_stall_i;
  assign fire        = dec_valid_i && dec_take_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= 32'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 32; i++) rf_vld_q[i] <= 1'b0;
      for (int i = 0; i < int'(DMEM_WORDS); i++) mem_vld_q[i] <= 1'b0;
    end else begin
      if (dec_take_o) out_valid_q <= dec_valid_i;
      if (fire) begin
        pc_q <= pc_d;
        if (wr) rf_vld_q[dec_i.rd] <= 1'b1;
        if (st) mem_vld_q[widx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (wr) rf_q[dec_i.rd] <= val;
      if (st) mem_q[widx] <= b;
      next_pc_o       <= pc_d;
      reg_written_o   <= wr;
      dest_reg_o      <= wr ? dec_i.rd : 5'd0;
      dest_value_o    <= val;
      mem_stored_o    <= st;
      store_address_o <= st ? addr : 32'd0;
      store_value_o   <= st ? b : 32'd0;
      unsupported_o   <= bad;
    end
  end

`ifndef ASSERT_OFF
  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> !(wr && dec_i.rd == 5'd0)) else $error("x0 written");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(next_pc_o)) else $error("result changed");
  a_pc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && bad) |=> pc_q == $past(pc_q) + 32'd4) else $error("bad op pc");
`endif

endmodule

// ----- hdl/rv32i_subset_single_cycle_core_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_subset_single_cycle_core_top
// rv32i subset core: decode front, short queue, execute back
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// in       | in_valid_i/stall_o   | instruction_i
// out      | out_valid_o/stall_i  | next_pc_o .. unsupported_o
//
// one instruction per clock sustained unless the output stalls; execute reads
// registers, pc and memory in the same cycle it updates them, so that single
// step sets the rate; an instruction passes the queue, then the result register
// reset clears pc, register and memory valid bits at once, no clearing pass
// a stalled output backs up into the two-entry queue, then stalls the input
module rv32i_subset_single_cycle_core_top #(
  parameter int unsigned DMEM_WORDS = rvsc_pkg::DmemWordsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        instruction_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        next_pc_o,
  output logic               reg_written_o,
  output logic [4:0]         dest_reg_o,
  output logic signed [31:0] dest_value_o,
  output logic               mem_stored_o,
  output logic [31:0]        store_address_o,
  output logic signed [31:0] store_value_o,
  output logic               unsupported_o
);

  // decoded beat between front and back
  rvsc_pkg::dec_t dec;
  logic           dec_valid, dec_take;

  rvsc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .instruction_i,
    .dec_valid_o (dec_valid),
    .dec_take_i  (dec_take),
    .dec_o       (dec)
  );

  rvsc_back #(.DMEM_WORDS(DMEM_WORDS)) u_back (
    .clk_i, .rst_ni,
    .dec_valid_i (dec_valid),
    .dec_take_o  (dec_take),
    .dec_i       (dec),
    .out_valid_o, .out_stall_i, .next_pc_o, .reg_written_o, .dest_reg_o,
    .dest_value_o, .mem_stored_o, .store_address_o, .store_value_o,
    .unsupported_o
  );

endmodule
